FILE: src/bmrdd_pkg.sv
// ----------------------------------------------------------------------------
// bmrdd_pkg
// Shared types and constants of the bit-mask row delta decoder.
// ----------------------------------------------------------------------------
package bmrdd_pkg;

	localparam int MAX_ROW_BYTES_DEF = 64;
	localparam int APB_AW            = 4;

	localparam logic [6:0]  ROW_BYTES_RST      = 7'd8;
	localparam logic [15:0] ROWS_PER_PLANE_RST = 16'd16;
	localparam logic [3:0]  PLANE_COUNT_RST    = 4'd1;
	localparam logic [3:0]  MAX_PLANES         = 4'd8;
	localparam logic [3:0]  TAKEN_MAX          = 4'd15;

	localparam logic [1:0] REG_ROW_BYTES      = 2'd0;
	localparam logic [1:0] REG_ROWS_PER_PLANE = 2'd1;
	localparam logic [1:0] REG_PLANE_COUNT    = 2'd2;

	typedef enum logic [1:0] {
		PH_RAW,
		PH_MASK,
		PH_BODY
	} phase_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_PROC,
		ST_DRAIN
	} state_t;

	typedef struct packed {
		logic [6:0]  row_bytes;
		logic [15:0] rows;
		logic [3:0]  planes;
		logic [3:0]  mask_need;
	} cfg_t;

	typedef struct packed {
		logic take;
		logic merge;
		logic emit_lit;
		logic emit_copy;
	} cmd_t;

	typedef struct packed {
		phase_t phase;
		logic   cont;
		logic   cont_after;
		logic   mask_done;
		logic   slot_free;
	} sts_t;

endpackage

FILE: src/bmrdd_if.sv
// ----------------------------------------------------------------------------
// bmrdd_in_if / bmrdd_out_if
// Valid/ready channels for compressed input bytes and decoded output bytes.
// ----------------------------------------------------------------------------
interface bmrdd_in_if;
	logic       valid;
	logic       ready;
	logic [7:0] compressed_byte;
	logic       first_of_tile;

	modport source (output valid, output compressed_byte, output first_of_tile, input ready);
	modport sink (input valid, input compressed_byte, input first_of_tile, output ready);
endinterface

interface bmrdd_out_if;
	logic       valid;
	logic       ready;
	logic [7:0] pixel_byte;
	logic       row_end;
	logic       tile_end;
	logic       run_last;

	modport source (output valid, output pixel_byte, output row_end, output tile_end,
		output run_last, input ready);
	modport sink (input valid, input pixel_byte, input row_end, input tile_end,
		input run_last, output ready);
endinterface

FILE: src/bmrdd_ram.sv
// ----------------------------------------------------------------------------
// bmrdd_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module bmrdd_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 64
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

FILE: src/bmrdd_cfg.sv
// ----------------------------------------------------------------------------
// bmrdd_cfg
// APB register file with the clamped values the decoder works with.
// ----------------------------------------------------------------------------
module bmrdd_cfg #(
	parameter int MAX_ROW_BYTES = bmrdd_pkg::MAX_ROW_BYTES_DEF
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         psel,
	input  logic                         penable,
	input  logic                         pwrite,
	input  logic [bmrdd_pkg::APB_AW-1:0] paddr,
	input  logic [31:0]                  pwdata,
	output logic [31:0]                  prdata,
	output logic                         pready,
	output bmrdd_pkg::cfg_t              cfg
);
	import bmrdd_pkg::*;

	logic [6:0]  row_bytes_q;
	logic [15:0] rows_q;
	logic [3:0]  planes_q;
	logic        wr_en;
	logic [1:0]  reg_idx;
	logic [6:0]  rb_eff;
	logic [7:0]  rb_round;

	assign pready  = 1'b1;
	assign wr_en   = psel && penable && pwrite;
	assign reg_idx = paddr[3:2];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			row_bytes_q <= ROW_BYTES_RST;
			rows_q      <= ROWS_PER_PLANE_RST;
			planes_q    <= PLANE_COUNT_RST;
		end else if (wr_en) begin
			unique case (reg_idx)
				REG_ROW_BYTES:      row_bytes_q <= pwdata[6:0];
				REG_ROWS_PER_PLANE: rows_q      <= pwdata[15:0];
				REG_PLANE_COUNT:    planes_q    <= pwdata[3:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		unique case (reg_idx)
			REG_ROW_BYTES:      prdata = {25'd0, row_bytes_q};
			REG_ROWS_PER_PLANE: prdata = {16'd0, rows_q};
			REG_PLANE_COUNT:    prdata = {28'd0, planes_q};
			default:            prdata = 32'd0;
		endcase
	end

	always_comb begin
		if (row_bytes_q == 7'd0) begin
			rb_eff = 7'd1;
		end else if (row_bytes_q > 7'(MAX_ROW_BYTES)) begin
			rb_eff = 7'(MAX_ROW_BYTES);
		end else begin
			rb_eff = row_bytes_q;
		end
		rb_round = {1'b0, rb_eff} + 8'd7;
	end

	assign cfg.row_bytes = rb_eff;
	assign cfg.rows      = (rows_q == 16'd0) ? 16'd1 : rows_q;
	assign cfg.planes    = (planes_q == 4'd0) ? 4'd1 :
		((planes_q > MAX_PLANES) ? MAX_PLANES : planes_q);
	assign cfg.mask_need = rb_round[6:3];

endmodule

FILE: src/bmrdd_ctrl.sv
// ----------------------------------------------------------------------------
// bmrdd_ctrl
// Sequencer that accepts a byte, processes it and drains copy runs.
// ----------------------------------------------------------------------------
module bmrdd_ctrl (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            in_valid,
	output logic            in_ready,
	input  bmrdd_pkg::sts_t sts,
	output bmrdd_pkg::cmd_t cmd
);
	import bmrdd_pkg::*;

	state_t state_q;
	state_t state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (in_valid) begin
					state_d = ST_PROC;
				end
			end
			ST_PROC: begin
				if (sts.phase == PH_MASK) begin
					state_d = sts.mask_done ? ST_DRAIN : ST_IDLE;
				end else if (sts.slot_free) begin
					state_d = sts.cont_after ? ST_DRAIN : ST_IDLE;
				end
			end
			ST_DRAIN: begin
				if (!sts.cont) begin
					state_d = ST_IDLE;
				end else if (sts.slot_free) begin
					state_d = sts.cont_after ? ST_DRAIN : ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_comb begin
		in_ready = 1'b0;
		cmd      = '0;
		unique case (state_q)
			ST_IDLE: begin
				in_ready = 1'b1;
				cmd.take = in_valid;
			end
			ST_PROC: begin
				if (sts.phase == PH_MASK) begin
					cmd.merge = 1'b1;
				end else begin
					cmd.emit_lit = sts.slot_free;
				end
			end
			ST_DRAIN: begin
				cmd.emit_copy = sts.cont && sts.slot_free;
			end
			default: ;
		endcase
	end

endmodule

FILE: src/bmrdd_dp.sv
// ----------------------------------------------------------------------------
// bmrdd_dp
// Position counters, row mask, previous-row buffer and output register.
// ----------------------------------------------------------------------------
module bmrdd_dp #(
	parameter int MAX_ROW_BYTES = bmrdd_pkg::MAX_ROW_BYTES_DEF
) (
	input  logic            clk,
	input  logic            arst_n,
	input  bmrdd_pkg::cfg_t cfg,
	input  bmrdd_pkg::cmd_t cmd,
	output bmrdd_pkg::sts_t sts,
	input  logic [7:0]      compressed_byte,
	input  logic            first_of_tile,
	output logic            out_valid,
	input  logic            out_ready,
	output logic [7:0]      pixel_byte,
	output logic            row_end,
	output logic            tile_end,
	output logic            run_last
);
	import bmrdd_pkg::*;

	localparam int AW  = $clog2(MAX_ROW_BYTES);
	localparam int MB  = (MAX_ROW_BYTES + 7) / 8;
	localparam int MW  = MB * 8;
	localparam int MIW = $clog2(MW);

	logic [7:0]    in_byte_q;
	logic [6:0]    pos_q;
	logic [15:0]   row_q;
	logic [3:0]    plane_q;
	logic [3:0]    taken_q;
	logic [MW-1:0] mask_q;
	phase_t        phase_q;
	logic          out_valid_q;
	logic [7:0]    out_byte_q;
	logic          out_row_end_q;
	logic          out_tile_end_q;
	logic          out_run_last_q;

	logic          emit;
	logic [7:0]    emit_byte;
	logic [7:0]    ram_rdata;
	logic [6:0]    pos_inc;
	logic [15:0]   row_inc;
	logic [3:0]    plane_inc;
	logic          e_row_end;
	logic          row_wrap;
	logic          plane_wrap;
	logic          e_tile_end;
	logic [6:0]    e_pos;
	logic [15:0]   e_row;
	logic [3:0]    e_plane;
	phase_t        e_phase;
	logic [3:0]    taken_sat;
	logic [MW-1:0] mask_merged;
	logic [6:0]    pos_d;

	function automatic logic mask_bit(input logic [MW-1:0] m, input logic [6:0] p);
		logic [6:0] idx;
		idx = {p[6:3], ~p[2:0]};
		return (p < 7'(MW)) ? m[idx[MIW-1:0]] : 1'b0;
	endfunction

	assign emit      = cmd.emit_lit || cmd.emit_copy;
	assign emit_byte = cmd.emit_copy ? ram_rdata : in_byte_q;

	assign pos_inc    = pos_q + 7'd1;
	assign row_inc    = row_q + 16'd1;
	assign plane_inc  = plane_q + 4'd1;
	assign e_row_end  = pos_inc >= cfg.row_bytes;
	assign row_wrap   = row_inc >= cfg.rows;
	assign plane_wrap = plane_inc >= cfg.planes;
	assign e_tile_end = e_row_end && row_wrap && plane_wrap;

	always_comb begin
		e_pos   = pos_inc;
		e_row   = row_q;
		e_plane = plane_q;
		e_phase = phase_q;
		if (e_row_end) begin
			e_pos = 7'd0;
			e_row = row_wrap ? 16'd0 : row_inc;
			if (row_wrap) begin
				e_plane = plane_wrap ? 4'd0 : plane_inc;
			end
			e_phase = (e_row == 16'd0) ? PH_RAW : PH_MASK;
		end
	end

	always_comb begin
		taken_sat   = (taken_q == TAKEN_MAX) ? TAKEN_MAX : taken_q + 4'd1;
		mask_merged = mask_q;
		for (int k = 0; k < MB; k++) begin
			if (taken_q == 4'(k)) begin
				mask_merged[8*k +: 8] = mask_q[8*k +: 8] | in_byte_q;
			end
		end
	end

	always_comb begin
		if (cmd.take && first_of_tile) begin
			pos_d = 7'd0;
		end else if (emit) begin
			pos_d = e_pos;
		end else begin
			pos_d = pos_q;
		end
	end

	assign sts.phase      = phase_q;
	assign sts.cont       = (phase_q == PH_BODY) && (pos_q < cfg.row_bytes) &&
		!mask_bit(mask_q, pos_q);
	assign sts.cont_after = !e_row_end && (phase_q == PH_BODY) && !mask_bit(mask_q, pos_inc);
	assign sts.mask_done  = taken_sat >= cfg.mask_need;
	assign sts.slot_free  = !out_valid_q || out_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q   <= 7'd0;
			row_q   <= 16'd0;
			plane_q <= 4'd0;
			taken_q <= 4'd0;
			mask_q  <= '0;
			phase_q <= PH_RAW;
		end else if (cmd.take) begin
			if (first_of_tile) begin
				pos_q   <= 7'd0;
				row_q   <= 16'd0;
				plane_q <= 4'd0;
				taken_q <= 4'd0;
				mask_q  <= '0;
				phase_q <= PH_RAW;
			end
		end else if (cmd.merge) begin
			mask_q  <= mask_merged;
			taken_q <= taken_sat;
			if (sts.mask_done) begin
				phase_q <= PH_BODY;
			end
		end else if (emit) begin
			pos_q   <= e_pos;
			row_q   <= e_row;
			plane_q <= e_plane;
			phase_q <= e_phase;
			if (e_row_end) begin
				taken_q <= 4'd0;
				mask_q  <= '0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.take) begin
			in_byte_q <= compressed_byte;
		end
		if (emit) begin
			out_byte_q     <= emit_byte;
			out_row_end_q  <= e_row_end;
			out_tile_end_q <= e_tile_end;
			out_run_last_q <= !sts.cont_after;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (emit) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	bmrdd_ram #(
		.WIDTH (8),
		.DEPTH (MAX_ROW_BYTES)
	) u_row_ram (
		.clk   (clk),
		.we    (emit),
		.waddr (pos_q[AW-1:0]),
		.wdata (emit_byte),
		.raddr (pos_d[AW-1:0]),
		.rdata (ram_rdata)
	);

	assign out_valid  = out_valid_q;
	assign pixel_byte = out_byte_q;
	assign row_end    = out_row_end_q;
	assign tile_end   = out_tile_end_q;
	assign run_last   = out_run_last_q;

endmodule

FILE: src/bitmask_row_delta_decoder.sv
// ----------------------------------------------------------------------------
// bitmask_row_delta_decoder
// Decodes bit-mask row delta compressed planar tiles into row bytes.
// ----------------------------------------------------------------------------
// A raw or literal byte, once accepted, is emitted when the output slot is
// free; a mask byte is merged into the row mask. Every byte copied from the
// previous row follows at one per cycle unless the output stalls, as the row
// buffer's registered read always addresses the next position; the input is
// held off until a copy run has drained. Results leave through an output
// register. While one waits for its transfer the next byte can still be
// accepted, but no further result is produced until the waiting one has gone.
module bitmask_row_delta_decoder #(
	parameter int MAX_ROW_BYTES = bmrdd_pkg::MAX_ROW_BYTES_DEF
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         psel,
	input  logic                         penable,
	input  logic                         pwrite,
	input  logic [bmrdd_pkg::APB_AW-1:0] paddr,
	input  logic [31:0]                  pwdata,
	output logic [31:0]                  prdata,
	output logic                         pready,
	bmrdd_in_if.sink                     compressed,
	bmrdd_out_if.source                  pixels
);
	import bmrdd_pkg::*;

	cfg_t cfg;
	cmd_t cmd;
	sts_t sts;
	logic in_ready;

	bmrdd_cfg #(
		.MAX_ROW_BYTES (MAX_ROW_BYTES)
	) u_cfg (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	bmrdd_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (compressed.valid),
		.in_ready (in_ready),
		.sts      (sts),
		.cmd      (cmd)
	);

	bmrdd_dp #(
		.MAX_ROW_BYTES (MAX_ROW_BYTES)
	) u_dp (
		.clk             (clk),
		.arst_n          (arst_n),
		.cfg             (cfg),
		.cmd             (cmd),
		.sts             (sts),
		.compressed_byte (compressed.compressed_byte),
		.first_of_tile   (compressed.first_of_tile),
		.out_valid       (pixels.valid),
		.out_ready       (pixels.ready),
		.pixel_byte      (pixels.pixel_byte),
		.row_end         (pixels.row_end),
		.tile_end        (pixels.tile_end),
		.run_last        (pixels.run_last)
	);

	assign compressed.ready = in_ready;

endmodule

FILE: src/bmrdd_checker.sv
// ----------------------------------------------------------------------------
// bmrdd_checker
// Port-level checks of the decoder, bound to the top level.
// ----------------------------------------------------------------------------
module bmrdd_checker (
	input logic       clk,
	input logic       arst_n,
	input logic       in_valid,
	input logic       in_ready,
	input logic       out_valid,
	input logic       out_ready,
	input logic [7:0] pixel_byte,
	input logic       row_end,
	input logic       tile_end,
	input logic       run_last
);

	// A result that is not taken stays in place.
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(pixel_byte) && $stable(row_end) &&
		$stable(tile_end) && $stable(run_last))
		else $error("stalled result changed");

	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && tile_end |-> row_end)
		else $error("tile end without row end");

	// While a run is still being produced, no new input may be taken.
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !run_last |-> !in_ready)
		else $error("input ready in the middle of a run");

	assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> !in_ready)
		else $error("input taken on consecutive cycles");

endmodule

bind bitmask_row_delta_decoder bmrdd_checker u_bmrdd_checker (
	.clk        (clk),
	.arst_n     (arst_n),
	.in_valid   (compressed.valid),
	.in_ready   (compressed.ready),
	.out_valid  (pixels.valid),
	.out_ready  (pixels.ready),
	.pixel_byte (pixels.pixel_byte),
	.row_end    (pixels.row_end),
	.tile_end   (pixels.tile_end),
	.run_last   (pixels.run_last)
);

FILE: tb/tb_bitmask_row_delta_decoder.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_bitmask_row_delta_decoder
// Self-checking testbench for the bit-mask row delta decoder. Compressed bytes
// are driven over the input channel and decoded bytes are drained from the
// output channel, both with random idle bursts. A scoreboard class predicts
// every decoded byte and its row, tile and run flags, and compares each output
// transfer against the oldest prediction. Row width, rows per plane and plane
// count are changed over the APB port between stimulus phases, including the
// out-of-range values and changes in the middle of a tile.
// ----------------------------------------------------------------------------
import bmrdd_pkg::*;

typedef struct packed {
	logic [7:0] pixel_byte;
	logic       row_end;
	logic       tile_end;
	logic       run_last;
} pixel_t;

class row_delta_scoreboard;
	localparam int ROW_CAP = MAX_ROW_BYTES_DEF;

	logic [6:0]  row_bytes;
	logic [15:0] rows_per_plane;
	logic [3:0]  plane_count;

	logic [7:0]  prev_row [ROW_CAP];
	bit          prev_valid [ROW_CAP];
	logic [63:0] mask_bits;
	logic [6:0]  position;
	logic [3:0]  masks_taken;
	logic [15:0] row_index;
	logic [3:0]  plane_index;
	phase_t      phase;

	pixel_t      expected_q [$];
	pixel_t      run [$];
	int          errors;
	int          inputs_seen;
	int          pixels_seen;

	function new();
		row_bytes = ROW_BYTES_RST;
		rows_per_plane = ROWS_PER_PLANE_RST;
		plane_count = PLANE_COUNT_RST;
		foreach (prev_row[i]) begin
			prev_row[i] = 8'h00;
			prev_valid[i] = 1'b0;
		end
		mask_bits = '0;
		position = '0;
		masks_taken = '0;
		row_index = '0;
		plane_index = '0;
		phase = PH_RAW;
		errors = 0;
		inputs_seen = 0;
		pixels_seen = 0;
	endfunction

	function int unsigned width();
		if (row_bytes == 0) return 1;
		if (row_bytes > ROW_CAP) return ROW_CAP;
		return row_bytes;
	endfunction

	function int unsigned rows();
		return (rows_per_plane == 0) ? 1 : rows_per_plane;
	endfunction

	function int unsigned planes();
		if (plane_count == 0) return 1;
		if (plane_count > MAX_PLANES) return MAX_PLANES;
		return plane_count;
	endfunction

	function void write_reg(logic [1:0] idx, logic [31:0] value);
		case (idx)
			REG_ROW_BYTES: row_bytes = value[6:0];
			REG_ROWS_PER_PLANE: rows_per_plane = value[15:0];
			REG_PLANE_COUNT: plane_count = value[3:0];
			default: ;
		endcase
	endfunction

	// True when no byte of the previous row can be copied before it was written.
	function bit copy_safe();
		if (phase == PH_RAW) return 1'b1;
		for (int i = 0; i < width(); i++)
			if (!prev_valid[i]) return 1'b0;
		return 1'b1;
	endfunction

	function void put_byte(logic [7:0] b);
		pixel_t r;
		r = '0;
		r.pixel_byte = b;
		if (position < ROW_CAP) begin
			prev_row[position] = b;
			prev_valid[position] = 1'b1;
		end
		position++;
		if (position >= width()) begin
			r.row_end = 1'b1;
			position = '0;
			mask_bits = '0;
			masks_taken = '0;
			row_index++;
			if (row_index >= rows()) begin
				row_index = '0;
				plane_index++;
				if (plane_index >= planes()) begin
					plane_index = '0;
					r.tile_end = 1'b1;
				end
			end
			if (row_index == 0) begin
				phase = PH_RAW;
			end else begin
				phase = PH_MASK;
			end
		end
		run.push_back(r);
	endfunction

	function bit mask_bit(int unsigned i);
		if (i >= 64) return 1'b0;
		return mask_bits[8 * (i / 8) + 7 - i % 8];
	endfunction

	function void copy_run();
		while (phase == PH_BODY && position < width() && mask_bit(position) == 1'b0)
			put_byte(prev_row[position]);
	endfunction

	function void note_input(logic [7:0] b, logic first);
		int unsigned need;
		pixel_t      last;
		run.delete();
		inputs_seen++;
		if (first) begin
			plane_index = '0;
			row_index = '0;
			position = '0;
			masks_taken = '0;
			mask_bits = '0;
			phase = PH_RAW;
		end
		case (phase)
			PH_RAW: put_byte(b);
			PH_MASK: begin
				need = (width() + 7) / 8;
				if (masks_taken < 8) mask_bits |= 64'(b) << (8 * masks_taken);
				if (masks_taken < TAKEN_MAX) masks_taken++;
				if (masks_taken >= need) begin
					phase = PH_BODY;
					copy_run();
				end
			end
			default: begin
				put_byte(b);
				copy_run();
			end
		endcase
		if (run.size() > 0) begin
			last = run.pop_back();
			last.run_last = 1'b1;
			run.push_back(last);
		end
		foreach (run[i]) expected_q.push_back(run[i]);
	endfunction

	function void check_result(pixel_t got);
		pixel_t want;
		pixels_seen++;
		if (expected_q.size() == 0) begin
			errors++;
			$error("pixel_byte: expected none, actual %0h", got.pixel_byte);
			return;
		end
		want = expected_q.pop_front();
		if (got.pixel_byte !== want.pixel_byte) begin
			errors++;
			$error("pixel_byte: expected %0h, actual %0h", want.pixel_byte, got.pixel_byte);
		end
		if (got.row_end !== want.row_end) begin
			errors++;
			$error("row_end: expected %0b, actual %0b", want.row_end, got.row_end);
		end
		if (got.tile_end !== want.tile_end) begin
			errors++;
			$error("tile_end: expected %0b, actual %0b", want.tile_end, got.tile_end);
		end
		if (got.run_last !== want.run_last) begin
			errors++;
			$error("run_last: expected %0b, actual %0b", want.run_last, got.run_last);
		end
	endfunction
endclass

module tb_bitmask_row_delta_decoder;
	localparam int HALF_PERIOD  = 4;
	localparam int LATENCY      = 8;
	localparam int RANDOM_ITEMS = 460;

	logic              clk = 1'b0;
	logic              arst_n;
	logic              psel;
	logic              penable;
	logic              pwrite;
	logic [APB_AW-1:0] paddr;
	logic [31:0]       pwdata;
	logic [31:0]       prdata;
	logic              pready;

	bmrdd_in_if  compressed_if ();
	bmrdd_out_if pixel_if ();

	row_delta_scoreboard sb = new();

	bit src_idle;
	bit sink_idle;
	int settings;
	int random_items;
	int phase_no;

	bitmask_row_delta_decoder uut (
		.clk        (clk),
		.arst_n     (arst_n),
		.psel       (psel),
		.penable    (penable),
		.pwrite     (pwrite),
		.paddr      (paddr),
		.pwdata     (pwdata),
		.prdata     (prdata),
		.pready     (pready),
		.compressed (compressed_if),
		.pixels     (pixel_if)
	);

	always #(HALF_PERIOD) clk = ~clk;

	always @(posedge clk) begin
		pixel_t got;
		if (arst_n === 1'b1 && pixel_if.valid === 1'b1 && pixel_if.ready === 1'b1) begin
			got = {pixel_if.pixel_byte, pixel_if.row_end, pixel_if.tile_end, pixel_if.run_last};
			sb.check_result(got);
		end
	end

	initial begin
		wait (arst_n === 1'b1);
		forever begin
			@(negedge clk);
			if (sink_idle && $urandom_range(0, 7) == 0) begin
				pixel_if.ready <= 1'b0;
				repeat ($urandom_range(1, 13)) @(negedge clk);
			end
			pixel_if.ready <= 1'b1;
		end
	end

	initial begin
		#(64'd20_000_000);
		$display("Some tests failed");
		$finish;
	end

	task automatic reg_write(input logic [1:0] idx, input logic [31:0] value);
		@(negedge clk);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= APB_AW'({idx, 2'b00});
		pwdata <= value;
		@(negedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (pready !== 1'b1);
		sb.write_reg(idx, value);
	endtask

	task automatic configure(input logic [6:0] rb, input logic [15:0] rows,
			input logic [3:0] planes, input logic [2:0] which);
		if (which[0]) reg_write(REG_ROW_BYTES, {25'($urandom), rb});
		if (which[1]) reg_write(REG_ROWS_PER_PLANE, {16'($urandom), rows});
		if (which[2]) reg_write(REG_PLANE_COUNT, {28'($urandom), planes});
		@(negedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		settings++;
	endtask

	// Called at a falling edge; returns at the falling edge after the transfer.
	task automatic send_byte(input logic [7:0] b, input logic first);
		if (src_idle && $urandom_range(0, 5) == 0) begin
			compressed_if.valid <= 1'b0;
			repeat ($urandom_range(1, 13)) @(negedge clk);
		end
		compressed_if.valid <= 1'b1;
		compressed_if.compressed_byte <= b;
		compressed_if.first_of_tile <= first;
		do @(posedge clk); while (compressed_if.ready !== 1'b1);
		sb.note_input(b, first);
		@(negedge clk);
	endtask

	task automatic run_phase(input int count, input bit noise, input bit fresh);
		logic [7:0] b;
		logic       first;
		int         mask_mode;
		mask_mode = 2;
		@(negedge clk);
		for (int k = 0; k < count; k++) begin
			if (k == 0) begin
				first = fresh;
			end else if (noise) begin
				first = ($urandom_range(0, 3) == 0);
			end else begin
				first = ($urandom_range(0, 59) == 0);
			end
			b = 8'($urandom_range(0, 255));
			if (!noise && !first && sb.phase == PH_MASK) begin
				if (sb.masks_taken == 0) mask_mode = $urandom_range(0, 3);
				case (mask_mode)
					0: b = 8'h00;
					1: b = 8'hFF;
					default: ;
				endcase
			end
			send_byte(b, first);
		end
		compressed_if.valid <= 1'b0;
	endtask

	task automatic wait_idle();
		while (sb.expected_q.size() > 0) @(posedge clk);
		repeat (LATENCY) @(posedge clk);
	endtask

	task automatic directed();
		logic [7:0] raw_row [8] = '{8'h00, 8'hFF, 8'h01, 8'h80, 8'h55, 8'hAA, 8'h7F, 8'hFE};
		logic [7:0] lits [4] = '{8'h00, 8'hFF, 8'h5A, 8'hA5};
		@(negedge clk);
		foreach (raw_row[i]) send_byte(raw_row[i], i == 0);
		send_byte(8'h00, 1'b0);
		send_byte(8'hA5, 1'b0);
		foreach (lits[i]) send_byte(lits[i], 1'b0);
		send_byte(8'h3C, 1'b0);
		send_byte(8'hC3, 1'b0);
		send_byte(8'h96, 1'b1);
		compressed_if.valid <= 1'b0;
	endtask

	initial begin
		logic [6:0]  rb;
		logic [15:0] rows;
		logic [3:0]  planes;
		logic [2:0]  which;
		int          count;
		bit          fresh;
		bit          noise;

		arst_n = 1'b0;
		psel = 1'b0;
		penable = 1'b0;
		pwrite = 1'b0;
		paddr = '0;
		pwdata = '0;
		compressed_if.valid = 1'b0;
		compressed_if.compressed_byte = '0;
		compressed_if.first_of_tile = 1'b0;
		pixel_if.ready = 1'b0;
		src_idle = 1'b1;
		sink_idle = 1'b1;
		settings = 0;
		random_items = 0;
		phase_no = 0;

		repeat (4) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		configure(7'd8, 16'd3, 4'd1, 3'b111);
		directed();

		while (random_items < RANDOM_ITEMS) begin
			wait_idle();
			which = 3'b111;
			case (phase_no)
				0: begin rb = 7'd0;   rows = 16'd0;     planes = 4'd0;  end
				1: begin rb = 7'h7F;  rows = 16'hFFFF;  planes = 4'hF;  end
				2: begin rb = 7'd64;  rows = 16'd1;     planes = 4'd8;  end
				3: begin rb = 7'd64;  rows = 16'd3;     planes = 4'd2;  end
				4: begin rb = 7'd1;   rows = 16'd1;     planes = 4'd1;  end
				default: begin
					case ($urandom_range(0, 9))
						0: rb = 7'd0;
						1: rb = 7'h7F;
						2: rb = 7'd64;
						3: rb = 7'd1;
						default: rb = 7'($urandom_range(1, 20));
					endcase
					case ($urandom_range(0, 7))
						0: rows = 16'd0;
						1: rows = 16'hFFFF;
						default: rows = 16'($urandom_range(1, 5));
					endcase
					case ($urandom_range(0, 7))
						0: planes = 4'd0;
						1: planes = 4'hF;
						2: planes = 4'd8;
						default: planes = 4'($urandom_range(1, 3));
					endcase
					which = 3'($urandom_range(1, 7));
				end
			endcase
			configure(rb, rows, planes, which);
			fresh = !sb.copy_safe() || $urandom_range(0, 2) == 0;
			noise = ($urandom_range(0, 5) == 0);
			count = $urandom_range(20, 40) + sb.width();
			if (random_items >= RANDOM_ITEMS - 80) begin
				src_idle = 1'b0;
				sink_idle = 1'b0;
			end else begin
				src_idle = ($urandom_range(0, 4) != 0);
				sink_idle = ($urandom_range(0, 4) != 0);
			end
			run_phase(count, noise, fresh);
			random_items += count;
			phase_no++;
		end
		wait_idle();

		$display("Drove %0d compressed bytes and checked %0d decoded bytes over %0d settings.",
			sb.inputs_seen, sb.pixels_seen, settings);
		$display("Rows up to the 64-byte cap, tile restarts and mid-tile register changes ran.");
		if (sb.errors == 0) begin
			$display("All tests passed");
		end else begin
			$display("Some tests failed");
		end
		$finish;
	end
endmodule

FILE: filelist.f
src/bmrdd_pkg.sv
src/bmrdd_if.sv
src/bmrdd_ram.sv
src/bmrdd_cfg.sv
src/bmrdd_ctrl.sv
src/bmrdd_dp.sv
src/bitmask_row_delta_decoder.sv
src/bmrdd_checker.sv
tb/tb_bitmask_row_delta_decoder.sv
